// ===== rtl/mf3_pkg.sv =====
// Shared types and constants of the 3x3 median filter.
package mf3_pkg;

    localparam int unsigned PIX_W     = 8;
    localparam int unsigned POS_W     = 10;
    localparam int unsigned CFG_W     = 11;
    localparam int unsigned CFG_IDX_W = 1;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_pixel;

    // Red values of one window column, ascending: [0] lowest, [2] highest.
    typedef logic [2:0][PIX_W-1:0] t_col;

    typedef struct packed {
        logic [PIX_W-1:0] red_in;
        logic [PIX_W-1:0] green_in;
        logic [PIX_W-1:0] blue_in;
    } t_in_item;

    typedef struct packed {
        logic [POS_W-1:0] out_row;
        logic [POS_W-1:0] out_col;
        logic [PIX_W-1:0] red_out;
        logic [PIX_W-1:0] green_out;
        logic [PIX_W-1:0] blue_out;
        logic             last_of_run;
        logic             frame_done;
    } t_out_item;

endpackage

// ===== rtl/median_filter_3x3_unit.sv =====
// Top level of the streaming 3x3 median filter over RGB frames.
//
// Pixels enter in raster order on the input channel (valid/ready); a transfer
// happens when valid and ready are both high. Results leave on the output
// channel in raster order (the last two rows interleave), each with its row and
// column. Interior pixels carry the median of the nine original red values in
// all three channels; border pixels pass through. last_of_run marks the final
// result caused by one input pixel; frame_done marks the bottom right pixel.
// A result passes stage 1, stage 2 and the output register after the transfer of
// the input that completes its window (one row and one column later).
// Throughput: one pixel per cycle while the receiver is ready. Each input yields
// at most one result except the last pixel of a row and pixels of the last row,
// which can yield two, and the final pixel, which yields four; every extra result
// stalls the input, since results leave one per cycle through the output register.
// Two lines are kept in one RAM of MAX_WIDTH entries, read when a pixel is
// taken and written back as the pixel moves on; it needs no clearing after reset.
// Reset restores 640 x 480 and the top left position. A configuration write
// restarts the frame. When the receiver stalls, results wait and the input
// side stops once the pipeline is full.
module median_filter_3x3_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  mf3_pkg::t_in_item             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output mf3_pkg::t_out_item            o_out_data,
    input  logic                          i_cfg_wr_en,
    input  logic [mf3_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mf3_pkg::CFG_W-1:0]     i_cfg_data
);

    import mf3_pkg::*;

    localparam int CW       = $clog2(MAX_WIDTH);
    localparam int RW       = $clog2(MAX_HEIGHT);
    localparam int PIX_BITS = $bits(t_pixel);
    localparam int W_RST    = ((640 > MAX_WIDTH) ? MAX_WIDTH : 640) - 1;
    localparam int H_RST    = ((480 > MAX_HEIGHT) ? MAX_HEIGHT : 480) - 1;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);

    localparam logic [1:0] SLOT_CENTER   = 2'd0;
    localparam logic [1:0] SLOT_ROW_END  = 2'd1;
    localparam logic [1:0] SLOT_LAST_ROW = 2'd2;
    localparam logic [1:0] SLOT_CORNER   = 2'd3;

    function automatic int clamp_last(input logic [CFG_W-1:0] v, input int maxv);
        int x;
        x = int'(v);
        if (x < 3) begin
            x = 3;
        end else if (x > maxv) begin
            x = maxv;
        end
        return x - 1;
    endfunction

    function automatic t_col sort3(input logic [PIX_W-1:0] a,
                                   input logic [PIX_W-1:0] b,
                                   input logic [PIX_W-1:0] c);
        logic [PIX_W-1:0] lo;
        logic [PIX_W-1:0] hi;
        t_col             r;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (c < lo) begin
            r = {hi, lo, c};
        end else if (c < hi) begin
            r = {hi, c, lo};
        end else begin
            r = {c, hi, lo};
        end
        return r;
    endfunction

    // frame geometry and raster position
    logic [CW-1:0] r_w_last;
    logic [RW-1:0] r_h_last;
    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;

    // stage 1: pixel waiting for its line store read
    logic          r_s1_valid;
    logic [RW-1:0] r_s1_row;
    logic [CW-1:0] r_s1_col;
    t_pixel        r_s1_px;

    // window of earlier columns
    t_col          r_win_col_a;
    t_col          r_win_col_b;
    t_pixel        r_win_mid;
    t_pixel        r_win_cur;

    // stage 2: pending results of one input
    logic [3:0]    r_s2_mask;
    logic [RW-1:0] r_s2_row;
    logic [CW-1:0] r_s2_col;
    logic          r_s2_med_en;
    t_col          r_s2_col_a;
    t_col          r_s2_col_b;
    t_col          r_s2_col_c;
    t_pixel        r_s2_pix [4];

    // output register
    logic          r_o_valid;
    t_out_item     r_o_data;

    logic [2*PIX_BITS-1:0] w_rd_data;
    t_pixel                w_up;
    t_pixel                w_low;
    t_col                  w_cur_col;
    logic [3:0]            w_new_mask;
    logic [3:0]            w_rest;
    logic                  w_out_load;
    logic                  w_emit;
    logic                  w_s2_free;
    logic                  w_s1_adv;
    logic                  w_accept;
    logic [1:0]            w_slot;
    logic [PIX_W-1:0]      w_median;
    logic [RW-1:0]         w_item_row;
    logic [CW-1:0]         w_item_col;
    t_pixel                w_item_pix;
    t_out_item             w_item;

    assign w_out_load = !r_o_valid || i_out_ready;
    assign w_rest     = r_s2_mask & (r_s2_mask - 4'd1);
    assign w_emit     = w_out_load && (r_s2_mask != 4'd0);
    assign w_s2_free  = (r_s2_mask == 4'd0) || (w_out_load && (w_rest == 4'd0));
    assign w_s1_adv   = r_s1_valid && w_s2_free;
    assign o_in_ready = !r_s1_valid || w_s2_free;
    assign w_accept   = i_in_valid && o_in_ready;

    mf3_ram #(
        .WIDTH (2 * PIX_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_s1_adv),
        .i_wr_addr (r_s1_col),
        .i_wr_data ({w_low, r_s1_px}),
        .i_rd_en   (w_accept),
        .i_rd_addr (r_col),
        .o_rd_data (w_rd_data)
    );

    assign w_up      = w_rd_data[2*PIX_BITS-1:PIX_BITS];
    assign w_low     = w_rd_data[PIX_BITS-1:0];
    assign w_cur_col = sort3(w_up.red, w_low.red, r_s1_px.red);

    always_comb begin
        w_new_mask[SLOT_CENTER]   = (r_s1_row != '0) && (r_s1_col != '0);
        w_new_mask[SLOT_ROW_END]  = (r_s1_row != '0) && (r_s1_col == r_w_last);
        w_new_mask[SLOT_LAST_ROW] = (r_s1_row == r_h_last) && (r_s1_col != '0);
        w_new_mask[SLOT_CORNER]   = (r_s1_row == r_h_last) && (r_s1_col == r_w_last);
    end

    // configuration and raster position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_last <= CW'(W_RST);
            r_h_last <= RW'(H_RST);
            r_row    <= '0;
            r_col    <= '0;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == CFG_FRAME_WIDTH) begin
                r_w_last <= CW'(clamp_last(i_cfg_data, MAX_WIDTH));
            end
            if (i_cfg_index == CFG_FRAME_HEIGHT) begin
                r_h_last <= RW'(clamp_last(i_cfg_data, MAX_HEIGHT));
            end
            r_row <= '0;
            r_col <= '0;
        end else if (w_accept) begin
            if (r_col == r_w_last) begin
                r_col <= '0;
                r_row <= (r_row == r_h_last) ? '0 : r_row + RW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_row <= r_row;
            r_s1_col <= r_col;
            r_s1_px  <= {i_in_data.red_in, i_in_data.green_in, i_in_data.blue_in};
        end
    end

    // window shift and stage 2 load
    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_win_col_a <= r_win_col_b;
            r_win_col_b <= w_cur_col;
            r_win_mid   <= w_low;
            r_win_cur   <= r_s1_px;
            r_s2_row    <= r_s1_row;
            r_s2_col    <= r_s1_col;
            r_s2_med_en <= (r_s1_row > RW'(1)) && (r_s1_col > CW'(1));
            r_s2_col_a  <= r_win_col_a;
            r_s2_col_b  <= r_win_col_b;
            r_s2_col_c  <= w_cur_col;
            r_s2_pix[SLOT_CENTER]   <= r_win_mid;
            r_s2_pix[SLOT_ROW_END]  <= w_low;
            r_s2_pix[SLOT_LAST_ROW] <= r_win_cur;
            r_s2_pix[SLOT_CORNER]   <= r_s1_px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_mask <= 4'd0;
        end else if (w_s1_adv) begin
            r_s2_mask <= w_new_mask;
        end else if (w_emit) begin
            r_s2_mask <= w_rest;
        end
    end

    // pick the next pending result
    always_comb begin
        priority if (r_s2_mask[SLOT_CENTER]) begin
            w_slot = SLOT_CENTER;
        end else if (r_s2_mask[SLOT_ROW_END]) begin
            w_slot = SLOT_ROW_END;
        end else if (r_s2_mask[SLOT_LAST_ROW]) begin
            w_slot = SLOT_LAST_ROW;
        end else begin
            w_slot = SLOT_CORNER;
        end
    end

    mf3_median u_median (
        .i_col_a  (r_s2_col_a),
        .i_col_b  (r_s2_col_b),
        .i_col_c  (r_s2_col_c),
        .o_median (w_median)
    );

    always_comb begin
        w_item_row = ((w_slot == SLOT_CENTER) || (w_slot == SLOT_ROW_END)) ?
                     r_s2_row - RW'(1) : r_s2_row;
        w_item_col = ((w_slot == SLOT_CENTER) || (w_slot == SLOT_LAST_ROW)) ?
                     r_s2_col - CW'(1) : r_s2_col;
        if ((w_slot == SLOT_CENTER) && r_s2_med_en) begin
            w_item_pix = {w_median, w_median, w_median};
        end else begin
            w_item_pix = r_s2_pix[w_slot];
        end
        w_item.out_row     = POS_W'(w_item_row);
        w_item.out_col     = POS_W'(w_item_col);
        w_item.red_out     = w_item_pix.red;
        w_item.green_out   = w_item_pix.green;
        w_item.blue_out    = w_item_pix.blue;
        w_item.last_of_run = (w_rest == 4'd0);
        w_item.frame_done  = (w_slot == SLOT_CORNER);
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_emit) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_o_data <= w_item;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_data;

endmodule

// ===== rtl/mf3_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module mf3_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/mf3_median.sv =====
// Median of nine red values given as three column-sorted triples.
module mf3_median (
    input  mf3_pkg::t_col              i_col_a,
    input  mf3_pkg::t_col              i_col_b,
    input  mf3_pkg::t_col              i_col_c,
    output logic [mf3_pkg::PIX_W-1:0]  o_median
);

    import mf3_pkg::*;

    function automatic logic [PIX_W-1:0] min2(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [PIX_W-1:0] max2(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b);
        return (a < b) ? b : a;
    endfunction

    function automatic logic [PIX_W-1:0] med3(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b,
                                              input logic [PIX_W-1:0] c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    logic [PIX_W-1:0] w_lo_max;
    logic [PIX_W-1:0] w_mid_med;
    logic [PIX_W-1:0] w_hi_min;

    assign w_lo_max  = max2(max2(i_col_a[0], i_col_b[0]), i_col_c[0]);
    assign w_mid_med = med3(i_col_a[1], i_col_b[1], i_col_c[1]);
    assign w_hi_min  = min2(min2(i_col_a[2], i_col_b[2]), i_col_c[2]);
    assign o_median  = med3(w_lo_max, w_mid_med, w_hi_min);

endmodule
